// ----- src/sha_pkg.sv -----
// package for the segment hole allocator: word types, region kinds, status codes
// no dependencies
`default_nettype none
package sha_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
	localparam int CNT_BITS = IDX_BITS + 1;
	localparam int ADDR_BITS = 20;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_HOLE = 2'd0;
	localparam kind_t KIND_PRE = 2'd1;
	localparam kind_t KIND_SEG = 2'd2;

	typedef logic [1:0] stat_t;
	localparam stat_t ST_OK = 2'd0;
	localparam stat_t ST_NOFIT = 2'd1;
	localparam stat_t ST_FULL = 2'd2;
	localparam stat_t ST_BAD = 2'd3;

	typedef logic [1:0] op_t;
	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_CLOSE = 2'd1;
	localparam op_t OP_ALLOC = 2'd2;
	localparam op_t OP_READ = 2'd3;

	localparam logic CFG_FIT_MODE = 1'b0;
	localparam logic CFG_MEM_SIZE = 1'b1;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] size;
		kind_t kind;
		logic [7:0] process;
		logic [5:0] segment;
	} region_t;

	typedef struct packed {
		op_t op;
		logic [ADDR_BITS-1:0] hole_base;
		logic [ADDR_BITS-1:0] req_length;
		logic [7:0] process_id;
		logic [5:0] segment_number;
		logic [5:0] entry_index;
	} in_word_t;

	typedef struct packed {
		stat_t status;
		logic [ADDR_BITS-1:0] result_base;
		logic [ADDR_BITS-1:0] result_length;
		kind_t region_kind_out;
		logic [7:0] owner_process;
		logic [5:0] owner_segment;
		logic [6:0] used_entries;
	} out_word_t;

	typedef struct packed {
		logic we;
		logic [IDX_BITS-1:0] waddr;
		region_t wdata;
		logic [IDX_BITS-1:0] raddr;
	} mem_req_t;
endpackage
`default_nettype wire

// ----- src/sha_table.sv -----
// region table memory: one write port, one registered read port
// depends on sha_pkg
`default_nettype none
module sha_table (
	input wire logic clk,
	input wire sha_pkg::mem_req_t req,
	output sha_pkg::region_t rdata
);
	import sha_pkg::*;
	region_t mem [TABLE_ENTRIES];
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		rdata <= mem[req.raddr];
	end
endmodule
`default_nettype wire

// ----- src/segment_hole_allocator.sv -----
// segment hole allocator top level: sequencer around the region table memory
// depends on sha_pkg and sha_table
// Usage: an input word (op, hole_base, req_length, process_id, segment_number,
// entry_index) is taken when in_valid is high and in_stall low; one result
// word follows on out_valid, held until out_stall is low. One word is worked
// at a time. Add hole passes through S_ADD, then S_LAST when a new entry is
// written; close goes to S_LAST when it writes an entry; read passes S_RDW, S_RD.
// Allocate scans the table through the single memory read port, one entry per
// cycle, then on a split moves the entries above the chosen hole up by one,
// one entry per cycle. The result sits in an output register; the next word
// is accepted as soon as that register is free or being emptied, so a stalled
// receiver holds only the finished word.
// Reset clears the counters, the layout end, out_valid and the found flag and
// sets the configuration (fit_mode 0, memory_size 1048575); table contents
// are undefined until written.
// Configuration: cfg_we with cfg_index 0 (fit_mode) or 1 (memory_size).
`default_nettype none
module segment_hole_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire sha_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output sha_pkg::out_word_t out_word,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [19:0] cfg_data
);
	import sha_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_LAST = 9'b000000010,
		S_ADD = 9'b000000100,
		S_RDW = 9'b000001000,
		S_RD = 9'b000010000,
		S_SCAN = 9'b000100000,
		S_PICK = 9'b001000000,
		S_SHIFT = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;
	in_word_t req_q;
	logic fit_mode_q;
	logic [ADDR_BITS-1:0] mem_size_q, layout_end_q;
	logic [CNT_BITS-1:0] total_q;
	logic [CNT_BITS-1:0] scan_q, pick_q, mv_q;
	logic found_q;
	region_t best_q;
	logic out_valid_q;
	out_word_t out_q;
	mem_req_t mreq;
	region_t rdata;

	sha_table u_table (.clk(clk), .req(mreq), .rdata(rdata));

	logic accept;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	logic [ADDR_BITS:0] hole_end;
	logic merge, gap;
	logic [1:0] need;
	logic [CNT_BITS:0] tot_need;
	logic [CNT_BITS-1:0] last_idx, mv_src;
	logic fits, better;
	assign hole_end = {1'b0, req_q.hole_base} + {1'b0, req_q.req_length};
	assign gap = req_q.hole_base > layout_end_q;
	assign merge = (req_q.hole_base == layout_end_q) && (total_q != '0)
		&& (rdata.kind == KIND_HOLE);
	assign need = gap ? 2'd2 : (merge ? 2'd0 : 2'd1);
	assign tot_need = {1'b0, total_q} + {{(CNT_BITS-1){1'b0}}, need};
	assign last_idx = total_q - 1'b1;
	assign mv_src = mv_q - 1'b1;
	assign fits = (rdata.kind == KIND_HOLE) && (rdata.size >= req_q.req_length);
	assign better = !found_q || (fit_mode_q && rdata.size < best_q.size);

	always_comb begin
		mreq = '0;
		case (state_q)
			S_IDLE: mreq.raddr = in_word.op == OP_READ ? in_word.entry_index
				: (in_word.op == OP_ADD ? last_idx[IDX_BITS-1:0] : '0);
			S_RDW: mreq.raddr = req_q.entry_index;
			S_SCAN: mreq.raddr = scan_q[IDX_BITS-1:0] + 1'b1;
			S_PICK: mreq.raddr = last_idx[IDX_BITS-1:0];
			S_SHIFT: mreq.raddr = mv_src[IDX_BITS-1:0] - 1'b1;
			default: mreq.raddr = '0;
		endcase
		if (state_q == S_ADD && gap && req_q.req_length != '0
			&& !(hole_end > {1'b0, mem_size_q}) && tot_need <= TABLE_ENTRIES) begin
			mreq.we = 1'b1;
			mreq.waddr = total_q[IDX_BITS-1:0];
			mreq.wdata = '{layout_end_q, req_q.hole_base - layout_end_q, KIND_PRE, 8'd0,
				6'd0};
		end
		if (state_q == S_SHIFT) begin
			mreq.we = 1'b1;
			if (mv_q == pick_q + 1'b1) begin
				mreq.waddr = mv_q[IDX_BITS-1:0];
				mreq.wdata = '{best_q.start + req_q.req_length,
					best_q.size - req_q.req_length, KIND_HOLE, 8'd0, 6'd0};
			end else begin
				mreq.waddr = mv_q[IDX_BITS-1:0];
				mreq.wdata = rdata;
			end
		end
		if (state_q == S_PICK && found_q && best_q.size == req_q.req_length) begin
			mreq.we = 1'b1;
			mreq.waddr = pick_q[IDX_BITS-1:0];
			mreq.wdata = '{best_q.start, best_q.size, KIND_SEG, req_q.process_id,
				req_q.segment_number};
		end
		if (state_q == S_DONE && found_q) begin
			mreq.we = 1'b1;
			mreq.waddr = pick_q[IDX_BITS-1:0];
			mreq.wdata = '{best_q.start, req_q.req_length, KIND_SEG, req_q.process_id,
				req_q.segment_number};
		end
		if (state_q == S_LAST) begin
			mreq.we = 1'b1;
			mreq.waddr = total_q[IDX_BITS-1:0];
			mreq.wdata = req_q.op == OP_CLOSE
				? region_t'{layout_end_q, mem_size_q - layout_end_q, KIND_PRE, 8'd0, 6'd0}
				: region_t'{req_q.hole_base, req_q.req_length, KIND_HOLE, 8'd0, 6'd0};
		end
		if (state_q == S_ADD && merge && !gap && req_q.req_length != '0
			&& !(hole_end > {1'b0, mem_size_q})) begin
			mreq.we = 1'b1;
			mreq.waddr = last_idx[IDX_BITS-1:0];
			mreq.wdata = rdata;
			mreq.wdata.size = rdata.size + req_q.req_length;
		end
	end

	function automatic out_word_t res(stat_t st, logic [CNT_BITS-1:0] n);
		out_word_t w;
		w = '0;
		w.status = st;
		w.used_entries = 7'(n);
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fit_mode_q <= 1'b0;
			mem_size_q <= 20'hFFFFF;
			layout_end_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
			scan_q <= '0;
			pick_q <= '0;
			mv_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FIT_MODE) fit_mode_q <= cfg_data[0];
				else mem_size_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) begin
					req_q <= in_word;
					case (in_word.op)
						OP_ADD: state_q <= S_ADD;
						OP_CLOSE: begin
							if (layout_end_q > mem_size_q) begin
								out_q <= res(ST_BAD, total_q);
								out_valid_q <= 1'b1;
							end else if (layout_end_q == mem_size_q) begin
								out_q <= res(ST_OK, total_q);
								out_valid_q <= 1'b1;
							end else if (total_q >= CNT_BITS'(TABLE_ENTRIES)) begin
								out_q <= res(ST_FULL, total_q);
								out_valid_q <= 1'b1;
							end else state_q <= S_LAST;
						end
						OP_ALLOC: begin
							scan_q <= '0;
							found_q <= 1'b0;
							if (in_word.req_length == '0 || total_q == '0) begin
								out_q <= res(ST_NOFIT, total_q);
								out_valid_q <= 1'b1;
							end else state_q <= S_SCAN;
						end
						default: state_q <= S_RDW;
					endcase
				end
				S_ADD: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
					out_q <= res(ST_OK, total_q);
					if (req_q.req_length == '0) begin
					end else if (req_q.hole_base < layout_end_q
						|| hole_end > {1'b0, mem_size_q}) begin
						out_q <= res(ST_BAD, total_q);
					end else if (tot_need > TABLE_ENTRIES) begin
						out_q <= res(ST_FULL, total_q);
					end else if (!merge) begin
						out_valid_q <= 1'b0;
						state_q <= S_LAST;
						if (gap) total_q <= total_q + 1'b1;
					end else layout_end_q <= hole_end[ADDR_BITS-1:0];
				end
				S_LAST: begin
					total_q <= total_q + 1'b1;
					layout_end_q <= req_q.op == OP_CLOSE ? mem_size_q
						: hole_end[ADDR_BITS-1:0];
					out_q <= res(ST_OK, total_q + 1'b1);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RDW: state_q <= S_RD;
				S_RD: begin
					out_q <= res(ST_BAD, total_q);
					if ({1'b0, req_q.entry_index} < total_q) begin
						out_q.result_base <= rdata.start;
						out_q.result_length <= rdata.size;
						out_q.region_kind_out <= rdata.kind;
						if (rdata.kind == KIND_SEG) begin
							out_q.owner_process <= rdata.process;
							out_q.owner_segment <= rdata.segment;
						end
						out_q.status <= ST_OK;
					end
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (fits && better) begin
						found_q <= 1'b1;
						best_q <= rdata;
						pick_q <= scan_q;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == last_idx || (fits && !fit_mode_q)) state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
					out_q <= res(ST_NOFIT, total_q);
					mv_q <= total_q;
					if (!found_q) begin
					end else if (best_q.size == req_q.req_length) begin
						out_q.status <= ST_OK;
						out_q.result_base <= best_q.start;
						out_q.result_length <= req_q.req_length;
						out_q.region_kind_out <= KIND_SEG;
						out_q.owner_process <= req_q.process_id;
						out_q.owner_segment <= req_q.segment_number;
					end else if (total_q >= CNT_BITS'(TABLE_ENTRIES)) begin
						out_q.status <= ST_FULL;
					end else begin
						out_valid_q <= 1'b0;
						state_q <= S_SHIFT;
						scan_q <= total_q;
					end
				end
				S_SHIFT: begin
					// read of mv_q-1 was issued the cycle before
					if (mv_q == pick_q + 1'b1) state_q <= S_DONE;
					else mv_q <= mv_q - 1'b1;
				end
				S_DONE: begin
					total_q <= total_q + 1'b1;
					out_q <= res(ST_OK, total_q + 1'b1);
					out_q.result_base <= best_q.start;
					out_q.result_length <= req_q.req_length;
					out_q.region_kind_out <= KIND_SEG;
					out_q.owner_process <= req_q.process_id;
					out_q.owner_segment <= req_q.segment_number;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// testbench for segment_hole_allocator: random and directed words checked against
// an in-bench predictor of the region table; depends on sha_pkg and the block's rtl
`default_nettype none
module tb;
	import sha_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [19:0] cfg_data = '0;

	segment_hole_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	in_word_t pending_words[$];
	out_word_t expected_results[$];
	int idle_pct = 25;
	int fails = 0;
	longint cycles = 0;

	// predictor state
	region_t regions[TABLE_ENTRIES];
	int used_count = 0;
	longint layout_end = 0;
	longint mem_size = 1048575;
	logic best_fit = 1'b0;

	function automatic out_word_t predict_result(in_word_t w);
		out_word_t r;
		longint base;
		longint len;
		int need;
		int pick;
		bit found;
		bit merge;
		r = '0;
		base = w.hole_base;
		len = w.req_length;
		pick = 0;
		found = 0;
		case (w.op)
			OP_ADD: begin
				if (len != 0) begin
					if (base < layout_end || base + len > mem_size) begin
						r.status = ST_BAD;
					end else begin
						merge = (base == layout_end) && used_count > 0 &&
							regions[used_count-1].kind == KIND_HOLE;
						need = (base > layout_end) ? 2 : (merge ? 0 : 1);
						if (used_count + need > TABLE_ENTRIES) begin
							r.status = ST_FULL;
						end else begin
							if (merge) begin
								regions[used_count-1].size += w.req_length;
							end else begin
								if (base > layout_end) begin
									regions[used_count] = '{layout_end[19:0],
										20'(base - layout_end), KIND_PRE, 8'd0, 6'd0};
									used_count++;
								end
								regions[used_count] = '{w.hole_base, w.req_length,
									KIND_HOLE, 8'd0, 6'd0};
								used_count++;
							end
							layout_end = base + len;
						end
					end
				end
			end
			OP_CLOSE: begin
				if (layout_end > mem_size) begin
					r.status = ST_BAD;
				end else if (layout_end < mem_size) begin
					if (used_count >= TABLE_ENTRIES) begin
						r.status = ST_FULL;
					end else begin
						regions[used_count] = '{layout_end[19:0],
							20'(mem_size - layout_end), KIND_PRE, 8'd0, 6'd0};
						used_count++;
						layout_end = mem_size;
					end
				end
			end
			OP_ALLOC: begin
				for (int i = 0; i < used_count; i++) begin
					if (regions[i].kind == KIND_HOLE && regions[i].size >= len) begin
						if (!found || (best_fit && regions[i].size < regions[pick].size)) begin
							pick = i;
							found = 1;
							if (!best_fit) break;
						end
					end
				end
				if (len == 0 || !found) begin
					r.status = ST_NOFIT;
				end else if (regions[pick].size == len) begin
					regions[pick].kind = KIND_SEG;
					regions[pick].process = w.process_id;
					regions[pick].segment = w.segment_number;
				end else if (used_count >= TABLE_ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					for (int j = used_count; j > pick + 1; j--) regions[j] = regions[j-1];
					regions[pick+1] = '{regions[pick].start + w.req_length,
						regions[pick].size - w.req_length, KIND_HOLE, 8'd0, 6'd0};
					regions[pick] = '{regions[pick].start, w.req_length, KIND_SEG,
						w.process_id, w.segment_number};
					used_count++;
				end
				if (r.status == ST_OK) begin
					r.result_base = regions[pick].start;
					r.result_length = w.req_length;
					r.region_kind_out = KIND_SEG;
					r.owner_process = w.process_id;
					r.owner_segment = w.segment_number;
				end
			end
			default: begin
				if (w.entry_index < used_count) begin
					r.result_base = regions[w.entry_index].start;
					r.result_length = regions[w.entry_index].size;
					r.region_kind_out = regions[w.entry_index].kind;
					if (regions[w.entry_index].kind == KIND_SEG) begin
						r.owner_process = regions[w.entry_index].process;
						r.owner_segment = regions[w.entry_index].segment;
					end
				end else begin
					r.status = ST_BAD;
				end
			end
		endcase
		r.used_entries = 7'(used_count);
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) expected_results.push_back(predict_result(in_word));
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					in_word <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [19:0] exp_val, logic [19:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fails++;
		end
	endtask

	// monitor
	out_word_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < idle_pct);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word");
					fails++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, out_word.status);
					check_field("result_base", want.result_base, out_word.result_base);
					check_field("result_length", want.result_length, out_word.result_length);
					check_field("region_kind_out", want.region_kind_out,
						out_word.region_kind_out);
					check_field("owner_process", want.owner_process, out_word.owner_process);
					check_field("owner_segment", want.owner_segment, out_word.owner_segment);
					check_field("used_entries", want.used_entries, out_word.used_entries);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 4000000) begin
			$display("segment_hole_allocator test failed");
			$finish;
		end
	end

	task automatic push_word(op_t op, int base, int len, int pid, int sg, int idx);
		in_word_t w;
		w.op = op;
		w.hole_base = base[19:0];
		w.req_length = len[19:0];
		w.process_id = pid[7:0];
		w.segment_number = sg[5:0];
		w.entry_index = idx[5:0];
		pending_words.push_back(w);
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic index, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[19:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_FIT_MODE) best_fit = value[0];
		else mem_size = value[19:0];
	endtask

	int cursor;
	int roll;
	int span;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// tiny memory: empty hole, single unit, bad order, exact fit, bad read
		write_reg(CFG_MEM_SIZE, 1);
		push_word(OP_ADD, 0, 0, 0, 0, 0);
		push_word(OP_ADD, 0, 1, 0, 0, 0);
		push_word(OP_ADD, 0, 1, 0, 0, 0);
		push_word(OP_CLOSE, 0, 0, 0, 0, 0);
		push_word(OP_ALLOC, 0, 0, 1, 1, 0);
		push_word(OP_ALLOC, 0, 1, 255, 63, 0);
		push_word(OP_ALLOC, 0, 1, 3, 3, 0);
		push_word(OP_READ, 0, 0, 0, 0, 0);
		push_word(OP_READ, 0, 0, 0, 0, 63);
		wait_drained();

		// gap, merge, beyond end, split, close, reads
		write_reg(CFG_MEM_SIZE, 100);
		push_word(OP_ADD, 10, 5, 0, 0, 0);
		push_word(OP_ADD, 15, 5, 0, 0, 0);
		push_word(OP_ADD, 30, 80, 0, 0, 0);
		push_word(OP_ADD, 30, 10, 0, 0, 0);
		push_word(OP_ALLOC, 0, 3, 7, 9, 0);
		push_word(OP_ALLOC, 0, 50, 7, 9, 0);
		push_word(OP_CLOSE, 0, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++) push_word(OP_READ, 0, 0, 0, 0, i);
		wait_drained();

		// best fit mode: close with layout past the end, then a best-fit allocate and a read
		write_reg(CFG_FIT_MODE, 1);
		write_reg(CFG_MEM_SIZE, 50);
		push_word(OP_CLOSE, 0, 0, 0, 0, 0);
		push_word(OP_ALLOC, 0, 2, 128, 32, 0);
		push_word(OP_READ, 0, 0, 0, 0, 3);
		wait_drained();

		cursor = 100;
		for (int phase = 0; phase < 6; phase++) begin
			idle_pct = (phase == 2) ? 0 : 25;
			write_reg(CFG_FIT_MODE, phase % 2);
			write_reg(CFG_MEM_SIZE, (phase == 5) ? 1048575 : cursor + 2000 + phase * 50000);
			for (int n = 0; n < 325; n++) begin
				roll = $urandom_range(99);
				if (roll < 20) begin
					span = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
					cursor += span;
					span = $urandom_range(1, 32);
					push_word(OP_ADD, cursor, span, 0, 0, 0);
					cursor += span;
				end else if (roll < 60) begin
					span = ($urandom_range(9) == 0) ? $urandom_range(0, 1048575)
						: $urandom_range(1, 24);
					push_word(OP_ALLOC, 0, span, $urandom_range(255), $urandom_range(63), 0);
				end else if (roll < 90) begin
					push_word(OP_READ, 0, 0, 0, 0, $urandom_range(63));
				end else if (roll < 94) begin
					push_word(OP_CLOSE, 0, 0, 0, 0, 0);
				end else begin
					push_word(op_t'($urandom_range(3)), $urandom_range(1048575),
						$urandom_range(1048575), $urandom_range(255), $urandom_range(63),
						$urandom_range(63));
				end
			end
			wait_drained();
			if (mem_size > cursor) cursor = int'(mem_size);
		end

		repeat (150) @(posedge clk);
		if (fails == 0) begin
			$display("segment_hole_allocator test passed");
		end else begin
			$display("segment_hole_allocator test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
